[src/slad_pkg.sv]
// ============================================================================
// slad_pkg: shared definitions for the sequential list core
// Field widths, operation codes, status codes and the default store depth.
// ============================================================================
package slad_pkg;

    // Default number of entries in the list store.
    localparam int DEFAULT_DEPTH = 16;

    // Field widths of the input and result words.
    localparam int OP_W      = 2;
    localparam int VALUE_W   = 32;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;
    localparam int REMOVED_W = 5;

    // Packed widths on the stream ports.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd4;

endpackage

[src/slad_ram.sv]
// ============================================================================
// slad_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ============================================================================
module slad_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/sequential_list_append_delete_core.sv]
// ============================================================================
// sequential_list_append_delete_core: ordered list with append, delete-all, read
// Keeps the list in one RAM and walks it to remove all matching entries.
// ============================================================================
// From an accepted word to its result word, append, unused codes and refused
// operations go straight to S_DONE; a read passes through S_RD, then S_DONE; a
// delete walks S_DEL, reading each stored entry once through the single read
// port, then S_DONE, which waits until the output register is free. One word is
// in work at a time; the core returns to idle as the result enters the output register.
// Reset clears the entry count and control state; the store keeps its data.
module sequential_list_append_delete_core
    import slad_pkg::*;
#(
    parameter int DEPTH = slad_pkg::DEFAULT_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: value [31:0], index [35:32], zero fill [39:36].
    input  logic [slad_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: op [1:0].
    input  logic [slad_pkg::OP_W-1:0]       s_tuser,
    // Result channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status [2:0], count [7:3], read_value [39:8], removed [44:40],
    // zero fill [47:45].
    output logic [slad_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DEL,
        S_RD,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          src_reg, src_next;
    logic [CW-1:0]          dst_reg, dst_next;
    logic                   pend_reg, pend_next;
    logic [VALUE_W-1:0]     val_reg, val_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [VALUE_W-1:0]     rdval_reg, rdval_next;
    logic [CW-1:0]          removed_reg, removed_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_W-1:0]     ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [VALUE_W-1:0]     ram_rdata;

    logic                   s_accept;
    logic [OP_W-1:0]        in_op;
    logic [VALUE_W-1:0]     in_value;
    logic [INDEX_W-1:0]     in_index;
    logic [AW+INDEX_W-1:0]  idx_ext;
    logic [CW+INDEX_W-1:0]  idx_cmp;
    logic [CW+INDEX_W-1:0]  cnt_cmp;
    logic [CW+COUNT_W-1:0]  cnt_out;
    logic [CW+REMOVED_W-1:0] rem_out;
    logic                   out_free;

    // Unpack the input word.
    assign in_op    = s_tuser;
    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_index = s_tdata[VALUE_W+INDEX_W-1:VALUE_W];
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Widened views for index compares and field packing.
    assign idx_ext = {{AW{1'b0}}, in_index};
    assign idx_cmp = {{CW{1'b0}}, in_index};
    assign cnt_cmp = {{INDEX_W{1'b0}}, cnt_reg};
    assign cnt_out = {{COUNT_W{1'b0}}, cnt_reg};
    assign rem_out = {{REMOVED_W{1'b0}}, removed_reg};

    // Next-state logic, RAM accesses and result assembly.
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        pend_next     = pend_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        rdval_next    = rdval_reg;
        removed_next  = removed_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg[AW-1:0];
        ram_wdata     = in_value;
        ram_raddr     = idx_ext[AW-1:0];

        // The output register empties when the result word is taken.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    val_next     = in_value;
                    status_next  = ST_OK;
                    rdval_next   = '0;
                    removed_next = '0;
                    state_next   = S_DONE;
                    unique case (in_op)
                        OP_APPEND: begin
                            if (cnt_reg >= CW'(DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                ram_we   = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        OP_DELETE: begin
                            if (cnt_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                src_next   = '0;
                                dst_next   = '0;
                                pend_next  = 1'b0;
                                state_next = S_DEL;
                            end
                        end
                        OP_READ: begin
                            if (idx_cmp >= cnt_cmp) begin
                                status_next = ST_RANGE;
                            end else begin
                                state_next = S_RD;
                            end
                        end
                        default: begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            // Walk the stored entries: issue one read a cycle and write each
            // survivor back at the compacted position in the next cycle, when its data returns.
            S_DEL: begin
                ram_raddr = src_reg[AW-1:0];
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                if (src_reg < cnt_reg) begin
                    src_next  = src_reg + CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg && (ram_rdata != val_reg)) begin
                    ram_we   = 1'b1;
                    dst_next = dst_reg + CW'(1);
                end
                if ((src_reg == cnt_reg) && !pend_reg) begin
                    removed_next = cnt_reg - dst_reg;
                    cnt_next     = dst_reg;
                    status_next  = (cnt_reg == dst_reg) ? ST_NOT_FOUND : ST_OK;
                    state_next   = S_DONE;
                end
            end

            // Read data arrives in the cycle after the address is presented.
            S_RD: begin
                rdval_next = ram_rdata;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000,
                                     rem_out[REMOVED_W-1:0],
                                     rdval_reg,
                                     cnt_out[COUNT_W-1:0],
                                     status_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            pend_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            pend_reg     <= pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        val_reg     <= val_next;
        status_reg  <= status_next;
        rdval_reg   <= rdval_next;
        removed_reg <= removed_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // List store.
    slad_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // The count never exceeds the store depth.
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("entry count exceeds store depth");

    // Compaction never writes ahead of the read pointer.
    a_dst_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEL) |-> (dst_reg <= src_reg))
        else $error("compaction write pointer passed read pointer");

    // The store is written only on append or during the delete walk.
    a_we_state: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == S_IDLE) || (state_reg == S_DEL)))
        else $error("store written outside append or delete");

    // A finished result is presented and the core returns to idle.
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && out_free) |=> (m_tvalid_reg && (state_reg == S_IDLE)))
        else $error("result not presented after completion");

endmodule
